### rtl/esma_pkg.sv
// Shared types and constants for the edge-shrinking moving average.
// Used by all but esma_ram and esma_queue; no dependencies.
`default_nettype none

package esma_pkg;

    localparam int HALF_MAX_DEF   = 16;
    localparam int RING_DEPTH_DEF = 64;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int SAMPLE_W = 20;
    localparam int WLEN_W   = 6;
    localparam int DATE_W   = YEAR_W + MONTH_W;
    localparam int ENTRY_W  = DATE_W + SAMPLE_W;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 26;
    localparam int STEP_W   = $clog2(SUM_W + 1);

    // job fields sized for the largest legal ring and half width
    localparam int JOB_AW = 8;
    localparam int JOB_HW = 5;
    localparam int JOB_CW = 6;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic              err;
        logic              fin;
        logic [JOB_AW-1:0] start;
        logic [JOB_HW-1:0] left;
        logic [JOB_CW-1:0] cnt;
    } t_job;

endpackage

`default_nettype wire

### rtl/esma_if.sv
// Valid/ready channel interfaces for the record input and the result output.
// Depends on esma_pkg for field widths.
`default_nettype none

interface esma_in_if;
    import esma_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [SAMPLE_W-1:0] sample;
    logic                last;

    modport source (output valid, year, month, sample, last, input ready);
    modport sink   (input valid, year, month, sample, last, output ready);
endinterface

interface esma_out_if;
    import esma_pkg::*;

    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [SAMPLE_W-1:0] mean;
    logic                final_res;
    logic                error;

    modport source (output valid, out_year, out_month, mean, final_res, error, input ready);
    modport sink   (input valid, out_year, out_month, mean, final_res, error, output ready);
endinterface

`default_nettype wire

### rtl/esma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module esma_ram #(
    parameter int W     = 38,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/esma_queue.sv
// Short job queue between the front (classifier) and the back (sum and divide).
// No package dependencies; the job is carried as a flat vector.
`default_nettype none

module esma_queue #(
    parameter int W     = 21,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);

    logic [W-1:0]   r_mem [DEPTH];
    logic [PTW-1:0] r_wp;
    logic [PTW-1:0] r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

endmodule

`default_nettype wire

### rtl/esma_front.sv
// Front end: accepts records, writes the ring, tracks series counters and
// turns each record into zero, one or (on last) many window jobs. Uses esma_pkg.
`default_nettype none

module esma_front #(
    parameter int HALF_MAX   = esma_pkg::HALF_MAX_DEF,
    parameter int RING_DEPTH = esma_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [esma_pkg::WLEN_W-1:0]   i_cfg_wdata,
    esma_in_if.sink                       i_in,
    input  logic                          i_q_empty,
    input  logic                          i_q_full,
    input  logic                          i_back_busy,
    output logic                          o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_addr,
    output logic [esma_pkg::ENTRY_W-1:0]  o_ram_wdata,
    output logic                          o_push,
    output esma_pkg::t_job                o_job
);
    import esma_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int HCAP = (HALF_MAX < (RING_DEPTH - 1) / 2) ? HALF_MAX : (RING_DEPTH - 1) / 2;
    localparam int HW   = $clog2(HCAP + 1);
    localparam int PW   = $clog2(HCAP + 2);

    typedef enum logic {F_IDLE, F_FLUSH} t_fstate;

    t_fstate         r_state, n_state;
    logic [AW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_pend, n_pend;
    logic [CNT_W-1:0] r_rc, n_rc;
    logic [CNT_W-1:0] r_ec, n_ec;
    logic [WLEN_W-1:0] r_wlen;

    logic            accept;
    logic [HW-1:0]   half;
    logic [AW-1:0]   cur_wr;
    logic [PW-1:0]   cur_pend;
    logic [PW-1:0]   pend_m1;
    logic [CNT_W-1:0] cur_rc;
    logic [CNT_W-1:0] ec_inc;
    logic            short_series;
    logic [AW:0]     pend_ext;
    logic [AW:0]     left_ext;
    logic [AW-1:0]   center;
    logic [AW-1:0]   start;
    logic [HW-1:0]   left;
    logic [HW-1:0]   right;
    t_job            job_calc;

    assign i_in.ready = (r_state == F_IDLE) && i_q_empty && !i_back_busy;
    assign accept     = i_in.valid && i_in.ready;

    assign o_ram_we    = accept;
    assign o_ram_addr  = r_wr;
    assign o_ram_wdata = {i_in.year, i_in.month, i_in.sample};

    assign half = ((r_wlen >> 1) > WLEN_W'(HCAP)) ? HW'(HCAP) : HW'(r_wlen >> 1);

    // in idle the record being accepted counts already
    assign cur_wr = (r_state == F_IDLE)
                  ? ((r_wr == AW'(RING_DEPTH - 1)) ? '0 : r_wr + 1'b1)
                  : r_wr;
    assign cur_pend = (r_state == F_IDLE) ? r_pend + 1'b1 : r_pend;
    assign pend_m1  = cur_pend - 1'b1;
    assign cur_rc   = (r_rc == '1) ? r_rc : r_rc + 1'b1;
    assign ec_inc   = (r_ec == '1) ? r_ec : r_ec + 1'b1;
    assign short_series = (cur_rc < {{(CNT_W - WLEN_W){1'b0}}, r_wlen});

    always_comb begin
        pend_ext = (AW + 1)'(cur_pend);
        if ({1'b0, cur_wr} >= pend_ext) begin
            center = AW'({1'b0, cur_wr} - pend_ext);
        end else begin
            center = AW'({1'b0, cur_wr} + (AW + 1)'(RING_DEPTH) - pend_ext);
        end
        left  = (r_ec < CNT_W'(half)) ? HW'(r_ec) : half;
        right = (pend_m1 < PW'(half)) ? HW'(pend_m1) : half;
        left_ext = (AW + 1)'(left);
        if ({1'b0, center} >= left_ext) begin
            start = AW'({1'b0, center} - left_ext);
        end else begin
            start = AW'({1'b0, center} + (AW + 1)'(RING_DEPTH) - left_ext);
        end
        job_calc.err   = 1'b0;
        job_calc.fin   = (r_state == F_FLUSH) && (cur_pend == PW'(1));
        job_calc.start = JOB_AW'(start);
        job_calc.left  = JOB_HW'(left);
        job_calc.cnt   = JOB_CW'(left) + JOB_CW'(right) + JOB_CW'(1);
    end

    always_comb begin
        n_state = r_state;
        n_wr    = r_wr;
        n_pend  = r_pend;
        n_rc    = r_rc;
        n_ec    = r_ec;
        o_push  = 1'b0;
        o_job   = '0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_wr   = cur_wr;
                    n_rc   = cur_rc;
                    n_pend = cur_pend;
                    if (i_in.last) begin
                        if (short_series) begin
                            // drop pending results, report a short series
                            o_push    = 1'b1;
                            o_job.err = 1'b1;
                            n_wr      = '0;
                            n_pend    = '0;
                            n_rc      = '0;
                            n_ec      = '0;
                        end else begin
                            n_state = F_FLUSH;
                        end
                    end else if (cur_pend > PW'(half)) begin
                        o_push = 1'b1;
                        o_job  = job_calc;
                        n_pend = pend_m1;
                        n_ec   = ec_inc;
                    end
                end
            end
            F_FLUSH: begin
                if (!i_q_full) begin
                    o_push = 1'b1;
                    o_job  = job_calc;
                    if (cur_pend == PW'(1)) begin
                        n_state = F_IDLE;
                        n_wr    = '0;
                        n_pend  = '0;
                        n_rc    = '0;
                        n_ec    = '0;
                    end else begin
                        n_pend = pend_m1;
                        n_ec   = ec_inc;
                    end
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wr    <= '0;
            r_pend  <= '0;
            r_rc    <= '0;
            r_ec    <= '0;
            r_wlen  <= WLEN_W'(1);
        end else begin
            r_state <= n_state;
            r_wr    <= n_wr;
            r_pend  <= n_pend;
            r_rc    <= n_rc;
            r_ec    <= n_ec;
            if (i_cfg_we) begin
                r_wlen <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/esma_back.sv
// Back end: pops window jobs, sums the window from the ring one entry a cycle,
// divides by the window count with a bit-serial divider, holds the result.
// Error jobs skip the ring and divider. Uses esma_pkg.
`default_nettype none

module esma_back #(
    parameter int RING_DEPTH = esma_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esma_pkg::t_job                i_job,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    output logic                          o_ram_re,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_raddr,
    input  logic [esma_pkg::ENTRY_W-1:0]  i_ram_rdata,
    output logic                          o_busy,
    esma_out_if.source                    o_out
);
    import esma_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    typedef enum logic [1:0] {B_IDLE, B_READ, B_DIV, B_DONE} t_bstate;

    t_bstate           r_state;
    logic [AW-1:0]     r_addr;
    logic [JOB_CW-1:0] r_issue;
    logic [JOB_CW-1:0] r_rcv;
    logic              r_rv;
    logic [JOB_HW-1:0] r_left;
    logic [JOB_CW-1:0] r_cnt;
    logic              r_fin;
    logic              r_err;
    logic [SUM_W-1:0]  r_sum;
    logic [DATE_W-1:0] r_date;
    logic [JOB_CW-1:0] r_rem;
    logic [STEP_W-1:0] r_step;

    logic                r_out_vld;
    logic [YEAR_W-1:0]   r_out_year;
    logic [MONTH_W-1:0]  r_out_month;
    logic [SAMPLE_W-1:0] r_out_mean;
    logic                r_out_fin;
    logic                r_out_err;

    logic              issue;
    logic [JOB_CW:0]   rem_sh;
    logic              ge;
    logic              out_free;

    assign o_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign issue       = (r_state == B_READ) && (r_issue != '0);
    assign o_ram_re    = issue;
    assign o_ram_raddr = r_addr;
    assign o_busy      = (r_state == B_READ);

    assign rem_sh   = {r_rem, r_sum[SUM_W-1]};
    assign ge       = (rem_sh >= {1'b0, r_cnt});
    assign out_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_rv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rv <= issue;
            // in B_DONE the output register is reloaded below instead
            if (r_out_vld && o_out.ready && (r_state != B_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_left  <= i_job.left;
                        r_cnt   <= i_job.cnt;
                        r_fin   <= i_job.fin;
                        r_err   <= i_job.err;
                        r_addr  <= i_job.start[AW-1:0];
                        r_issue <= i_job.cnt;
                        r_rcv   <= '0;
                        r_sum   <= '0;
                        r_date  <= '0;
                        r_state <= i_job.err ? B_DONE : B_READ;
                    end
                end
                B_READ: begin
                    if (issue) begin
                        r_addr  <= (r_addr == AW'(RING_DEPTH - 1)) ? '0 : r_addr + 1'b1;
                        r_issue <= r_issue - 1'b1;
                    end
                    if (r_rv) begin
                        r_sum <= r_sum + SUM_W'(i_ram_rdata[SAMPLE_W-1:0]);
                        // the center entry carries the date
                        if (r_rcv == JOB_CW'(r_left)) begin
                            r_date <= i_ram_rdata[ENTRY_W-1:SAMPLE_W];
                        end
                        r_rcv <= r_rcv + 1'b1;
                        if (r_rcv + 1'b1 == r_cnt) begin
                            r_rem   <= '0;
                            r_step  <= STEP_W'(SUM_W);
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    // restoring division, one quotient bit a cycle
                    r_rem  <= ge ? JOB_CW'(rem_sh - {1'b0, r_cnt}) : JOB_CW'(rem_sh);
                    r_sum  <= {r_sum[SUM_W-2:0], ge};
                    r_step <= r_step - 1'b1;
                    if (r_step == STEP_W'(1)) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_year  <= r_date[DATE_W-1:MONTH_W];
                        r_out_month <= r_date[MONTH_W-1:0];
                        r_out_mean  <= r_sum[SAMPLE_W-1:0];
                        r_out_fin   <= r_fin;
                        r_out_err   <= r_err;
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.out_year  = r_out_year;
    assign o_out.out_month = r_out_month;
    assign o_out.mean      = r_out_mean;
    assign o_out.final_res = r_out_fin;
    assign o_out.error     = r_out_err;

endmodule

`default_nettype wire

### rtl/edge_shrinking_moving_average.sv
// Top level of the edge-shrinking centered moving average.
// Depends on esma_pkg, esma_if, esma_ram, esma_queue, esma_front, esma_back.
//
//   Port          Dir   Handshake     Carries
//   i_in          in    valid/ready   year, month, sample, last
//   o_out         out   valid/ready   out_year, out_month, mean, final_res, error
//   i_cfg_*       in    write enable  window_length
//
// A record other than the last that yields no result does not stall the input.
// A result takes a job pop, one ring read per sample in the window
// (cnt = samples in the window), a bit-serial division and an output load;
// the single ring read port and the bit-serial divider set its cost.
// Input stalls while the back end reads the ring, while jobs are queued or
// while the front flushes after the last record. The last record releases
// up to h + 1 results. Reset is synchronous; no clearing pass.
`default_nettype none

module edge_shrinking_moving_average #(
    parameter int HALF_MAX   = esma_pkg::HALF_MAX_DEF,
    parameter int RING_DEPTH = esma_pkg::RING_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [esma_pkg::WLEN_W-1:0] i_cfg_wdata,
    esma_in_if.sink                     i_in,
    esma_out_if.source                  o_out
);
    import esma_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic               q_full;
    logic               back_busy;
    t_job               push_job;
    t_job               head_job;

    esma_ram #(
        .W     (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    esma_front #(
        .HALF_MAX   (HALF_MAX),
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_q_empty   (q_empty),
        .i_q_full    (q_full),
        .i_back_busy (back_busy),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    esma_queue #(
        .W     ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .i_pop   (q_pop),
        .o_data  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    esma_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_busy      (back_busy),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### rtl/esma_checker.sv
// Port-level checks for the moving average, attached to the top level by bind.
// Depends on esma_pkg for field widths.
`default_nettype none

module esma_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_last,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [esma_pkg::YEAR_W-1:0]   i_out_year,
    input logic [esma_pkg::MONTH_W-1:0]  i_out_month,
    input logic [esma_pkg::SAMPLE_W-1:0] i_mean,
    input logic                          i_final_res,
    input logic                          i_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mean)
            && $stable(i_out_year) && $stable(i_out_month)
            && $stable(i_final_res) && $stable(i_error))
        else $error("result changed while stalled");

    // a short-series result carries nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> i_mean == '0 && i_out_year == '0
            && i_out_month == '0 && !i_final_res)
        else $error("error result with nonzero fields");

    // the end of a series always leaves work behind, so input must stall
    a_last_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input ready right after last record");

endmodule

bind edge_shrinking_moving_average esma_checker u_esma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_year  (o_out.out_year),
    .i_out_month (o_out.out_month),
    .i_mean      (o_out.mean),
    .i_final_res (o_out.final_res),
    .i_error     (o_out.error)
);

`default_nettype wire
